// ----- rtl/core/hrfu_pkg.sv -----
// Shared types and constants for the HID report field unpacker.
// No dependencies; imported by every module of the block.
`default_nettype none

package hrfu_pkg;

  localparam int WORD_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_FIELD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGN_WIDTH   = 2'd2;

  localparam logic [8:0] RESET_FIELD_BITS = 9'd8;
  localparam logic [5:0] RESET_SIGN_WIDTH = 6'd8;

  // Request queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       report_start;
  } q_entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/hrfu_front.sv -----
// Front end: accepts report byte requests and holds them in a short queue.
// Depends on hrfu_pkg (q_entry_t, queue sizing).
`default_nettype none

module hrfu_front
  import hrfu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic     in_report_start,
  output logic          head_valid,
  output q_entry_t      head,
  input  wire logic     pop
);

  q_entry_t             q_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 push;

  assign in_stall   = (count_r == Q_CNT_W'(Q_DEPTH));
  assign push       = in_valid && !in_stall;
  assign head_valid = (count_r != '0);
  assign head       = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= '{data_byte: in_data_byte, report_start: in_report_start};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hrfu_back.sv -----
// Back end: bit-serial field engine, one report bit per cycle unless
// stalled, plus config and output registers. Depends on hrfu_pkg.
`default_nettype none

module hrfu_back
  import hrfu_pkg::*;
#(
  parameter int MAX_FIELD_BITS = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  head_valid,
  input  wire q_entry_t              head,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [WORD_W-1:0]          out_value_word,
  output logic [2:0]                 out_word_index,
  output logic                       out_last_word
);

  localparam int LEFT_W = $clog2(MAX_FIELD_BITS + 1);
  localparam logic [LEFT_W-1:0] MAX_LEFT = LEFT_W'(MAX_FIELD_BITS);

  function automatic logic [LEFT_W-1:0] eff_len(input logic [8:0] fb);
    logic [LEFT_W-1:0] n;
    if (fb == 9'd0) begin
      n = LEFT_W'(1);
    end else if (32'(fb) > 32'(MAX_FIELD_BITS)) begin
      n = MAX_LEFT;
    end else begin
      n = LEFT_W'(fb);
    end
    return n;
  endfunction

  function automatic logic [WORD_W-1:0] extend_sign(input logic [WORD_W-1:0] w,
                                                    input logic [5:0] sw);
    logic [5:0]        swe;
    logic [4:0]        sidx;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] res;
    swe  = (sw == 6'd0) ? 6'd1 : sw;
    sidx = swe[4:0] - 5'd1;
    mask = ~((WORD_W'(1) << swe[4:0]) - WORD_W'(1));
    res  = w;
    if (!swe[5] && w[sidx]) begin
      res = w | mask;
    end
    return res;
  endfunction

  logic [8:0]        field_bits_r;
  logic              signed_field_r;
  logic [5:0]        sign_width_r;

  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [4:0]        pos_r, pos_nxt;
  logic [LEFT_W-1:0] left_r, left_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [2:0]        bit_idx_r;

  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic [2:0]        out_index_r;
  logic              out_last_r;

  logic              can_go, go, start;
  logic [WORD_W-1:0] acc0, acc1;
  logic [4:0]        pos0;
  logic [5:0]        pos1;
  logic [LEFT_W-1:0] left0, left1;
  logic [2:0]        cnt0;
  logic              cur_bit, emit_last, emit_full;

  assign can_go = !out_valid_r || !out_stall;
  assign go     = head_valid && can_go;
  assign pop    = go && (bit_idx_r == 3'd7);
  assign start  = head.report_start && (bit_idx_r == 3'd0);

  always_comb begin
    acc0    = start ? '0 : acc_r;
    pos0    = start ? '0 : pos_r;
    cnt0    = start ? '0 : cnt_r;
    left0   = start ? eff_len(field_bits_r) : left_r;
    cur_bit = head.data_byte[bit_idx_r];
    acc1    = acc0 | (WORD_W'(cur_bit) << pos0);
    pos1    = {1'b0, pos0} + 6'd1;
    left1   = (left0 != '0) ? left0 - LEFT_W'(1) : '0;
    emit_last = (left1 == '0);
    emit_full = !emit_last && pos1[5];

    acc_nxt  = acc1;
    pos_nxt  = pos1[4:0];
    cnt_nxt  = cnt0;
    left_nxt = left1;
    if (emit_last) begin
      acc_nxt  = '0;
      pos_nxt  = '0;
      cnt_nxt  = '0;
      left_nxt = eff_len(field_bits_r);
    end else if (emit_full) begin
      acc_nxt = '0;
      pos_nxt = '0;
      cnt_nxt = cnt0 + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_bits_r   <= RESET_FIELD_BITS;
      signed_field_r <= 1'b0;
      sign_width_r   <= RESET_SIGN_WIDTH;
      acc_r          <= '0;
      pos_r          <= '0;
      cnt_r          <= '0;
      left_r         <= eff_len(RESET_FIELD_BITS);
      bit_idx_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_FIELD_BITS:   field_bits_r   <= cfg_data;
          REG_SIGNED_FIELD: signed_field_r <= cfg_data[0];
          REG_SIGN_WIDTH:   sign_width_r   <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (go) begin
        acc_r     <= acc_nxt;
        pos_r     <= pos_nxt;
        cnt_r     <= cnt_nxt;
        left_r    <= left_nxt;
        bit_idx_r <= bit_idx_r + 3'd1;
      end else if (cfg_wr && cfg_index == REG_FIELD_BITS && pos_r == '0 && cnt_r == '0) begin
        // nothing gathered yet in this field: new length applies at once
        left_r <= eff_len(cfg_data);
      end
      if (go) begin
        out_valid_r <= emit_last || emit_full;
      end else if (can_go) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && (emit_last || emit_full)) begin
      out_word_r  <= (emit_last && cnt0 == 3'd0 && signed_field_r) ?
                     extend_sign(acc1, sign_width_r) : acc1;
      out_index_r <= cnt0;
      out_last_r  <= emit_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value_word = out_word_r;
  assign out_word_index = out_index_r;
  assign out_last_word  = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/core/hid_report_field_unpacker.sv -----
// HID report field unpacker: top level.
// Cuts a byte stream, LSB first, into fields of field_bits bits and emits
// each field as one or more 32-bit words, the final one marked last_word.
// Input channel (in_*): one report byte per request, report_start drops
// any partial field before the byte's bits are used.
// Output channel (out_*): one word per request, held while out_stall is high.
// Config port (cfg_*): index 0 field_bits, 1 signed_field, 2 sign_width;
// other indexes ignored. cfg_ready is always high.
// Throughput: one bit per cycle through the back-end field engine while the
// output is not stalled; a byte may give 0 to 8 output words, at most one
// per cycle. A word is registered and visible in the cycle after its bit
// is processed. Bytes are held in the 2-entry request queue.
// Reset: queue and output empty, field_bits=8, signed_field=0, sign_width=8.
// Output stall freezes the engine; the queue keeps taking bytes until full,
// then in_stall rises.
// Depends on hrfu_pkg, hrfu_front, hrfu_back.
`default_nettype none

module hid_report_field_unpacker
  import hrfu_pkg::*;
#(
  parameter int MAX_FIELD_BITS = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_data_byte,
  input  wire logic                  in_report_start,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [WORD_W-1:0]          out_value_word,
  output logic [2:0]                 out_word_index,
  output logic                       out_last_word,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic     head_valid;
  q_entry_t head;
  logic     pop;

  assign cfg_ready = 1'b1;

  hrfu_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_report_start (in_report_start),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop)
  );

  hrfu_back #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value_word (out_value_word),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word)
  );

  // engine only retires a queue entry that is present
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue popped while empty");

  // reset empties both the queue and the output register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("state not cleared by reset");

  // a stalled word is never replaced by the engine
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_value_word) && $stable(out_word_index))
    else $error("output word changed under stall");

endmodule

`default_nettype wire
